// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CAF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/caf_pkg.sv =====
// ----------------------------------------------------------------------------
// caf_pkg
// Types, operation, condition and fault codes shared by the conditional ALU.
// ----------------------------------------------------------------------------
package caf_pkg;

    localparam int CAF_REG_COUNT = 16;
    localparam int WORD_W        = 32;

    localparam logic [3:0] KIND_ADD = 4'd0;
    localparam logic [3:0] KIND_AND = 4'd1;
    localparam logic [3:0] KIND_B   = 4'd2;
    localparam logic [3:0] KIND_BIC = 4'd3;
    localparam logic [3:0] KIND_CMP = 4'd4;
    localparam logic [3:0] KIND_EOR = 4'd5;
    localparam logic [3:0] KIND_MOV = 4'd6;
    localparam logic [3:0] KIND_MUL = 4'd7;
    localparam logic [3:0] KIND_ORR = 4'd8;
    localparam logic [3:0] KIND_SUB = 4'd9;

    localparam logic [4:0] COND_EQ = 5'd1;
    localparam logic [4:0] COND_NE = 5'd2;
    localparam logic [4:0] COND_CS = 5'd3;
    localparam logic [4:0] COND_CC = 5'd4;
    localparam logic [4:0] COND_MI = 5'd5;
    localparam logic [4:0] COND_PL = 5'd6;
    localparam logic [4:0] COND_VS = 5'd7;
    localparam logic [4:0] COND_VC = 5'd8;
    localparam logic [4:0] COND_HI = 5'd9;
    localparam logic [4:0] COND_LS = 5'd10;
    localparam logic [4:0] COND_GE = 5'd11;
    localparam logic [4:0] COND_LT = 5'd12;
    localparam logic [4:0] COND_GT = 5'd13;
    localparam logic [4:0] COND_LE = 5'd14;

    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_COUNT = 2'd1;
    localparam logic [1:0] FAULT_KIND  = 2'd2;

    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef struct packed {
        logic [3:0]        kind;
        logic [4:0]        cond;
        logic              set_flags;
        logic [1:0]        operand_count;
        logic [3:0]        dest_reg;
        logic              a_is_reg;
        logic [3:0]        a_reg;
        logic [WORD_W-1:0] a_imm;
        logic              b_is_reg;
        logic [3:0]        b_reg;
        logic [WORD_W-1:0] b_imm;
        logic [WORD_W-1:0] jump_target;
    } req_t;

    typedef struct packed {
        logic              executed;
        logic              reg_written;
        logic [3:0]        written_index;
        logic [WORD_W-1:0] result_value;
        logic [3:0]        flags_now;
        logic              branch_taken;
        logic [WORD_W-1:0] pc_now;
        logic [1:0]        fault;
    } res_t;

endpackage

// ===== rtl/core/caf_regfile.sv =====
// ----------------------------------------------------------------------------
// caf_regfile
// Register file memory: one write port, two registered read ports with
// write-to-read forwarding and per-entry valid bits for the zero reset.
// ----------------------------------------------------------------------------
module caf_regfile
    import caf_pkg::*;
#(
    parameter int REG_COUNT = CAF_REG_COUNT,
    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     raddr0,
    input  logic [AW-1:0]     raddr1,
    output logic [WORD_W-1:0] rdata0,
    output logic [WORD_W-1:0] rdata1,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata
);

    logic [WORD_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [WORD_W-1:0]    rdata0_reg;
    logic [WORD_W-1:0]    rdata1_reg;
    logic [WORD_W-1:0]    rdata0_next;
    logic [WORD_W-1:0]    rdata1_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // forward the write in flight
    always_comb
    begin
        if (we && (waddr == raddr0))
        begin
            rdata0_next = wdata;
        end
        else
        begin
            rdata0_next = vld_reg[raddr0] ? mem[raddr0] : '0;
        end
        if (we && (waddr == raddr1))
        begin
            rdata1_next = wdata;
        end
        else
        begin
            rdata1_next = vld_reg[raddr1] ? mem[raddr1] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata0_reg <= rdata0_next;
            rdata1_reg <= rdata1_next;
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ===== rtl/core/caf_exec.sv =====
// ----------------------------------------------------------------------------
// caf_exec
// Condition test, operand-count check, ALU and NZCV update for one request.
// ----------------------------------------------------------------------------
module caf_exec
    import caf_pkg::*;
(
    input  req_t              req,
    input  logic [WORD_W-1:0] x,
    input  logic [WORD_W-1:0] y,
    input  logic [3:0]        flags,
    input  logic [WORD_W-1:0] pc,
    input  logic [3:0]        wr_index,
    output res_t              res
);

    logic              n;
    logic              z;
    logic              c;
    logic              v;
    logic              pass;
    logic              ok;
    logic              cnt_23;
    logic [WORD_W-1:0] diff;
    logic [WORD_W-1:0] op_val;
    logic [3:0]        sub_f;

    assign n = flags[FLAG_N];
    assign z = flags[FLAG_Z];
    assign c = flags[FLAG_C];
    assign v = flags[FLAG_V];

    always_comb
    begin
        unique case (req.cond)
            COND_EQ: pass = z;
            COND_NE: pass = !z;
            COND_CS: pass = c;
            COND_CC: pass = !c;
            COND_MI: pass = n;
            COND_PL: pass = !n;
            COND_VS: pass = v;
            COND_VC: pass = !v;
            COND_HI: pass = c && !z;
            COND_LS: pass = !c || z;
            COND_GE: pass = (n == v);
            COND_LT: pass = (n != v);
            COND_GT: pass = !z && (n == v);
            COND_LE: pass = z || (n != v);
            default: pass = 1'b1;
        endcase
    end

    assign cnt_23 = (req.operand_count == CNT_TWO) || (req.operand_count == CNT_THREE);

    always_comb
    begin
        unique case (req.kind) inside
            KIND_ADD, KIND_BIC, KIND_SUB:           ok = cnt_23;
            KIND_AND, KIND_EOR, KIND_MUL, KIND_ORR: ok = (req.operand_count == CNT_THREE);
            KIND_CMP, KIND_MOV:                     ok = (req.operand_count == CNT_TWO);
            KIND_B:                                 ok = (req.operand_count == CNT_ONE);
            default:                                ok = 1'b0;
        endcase
    end

    assign diff = x - y;

    always_comb
    begin
        sub_f         = '0;
        sub_f[FLAG_N] = diff[WORD_W-1];
        sub_f[FLAG_Z] = (diff == '0);
        sub_f[FLAG_C] = (x >= y);
        sub_f[FLAG_V] = ((x ^ y) & (x ^ diff)) >> (WORD_W - 1) != '0;
    end

    always_comb
    begin
        case (req.kind)
            KIND_ADD: op_val = x + y;
            KIND_AND: op_val = x & y;
            KIND_BIC: op_val = x & ~y;
            KIND_EOR: op_val = x ^ y;
            KIND_MOV: op_val = y;
            KIND_MUL: op_val = WORD_W'(x * y);
            KIND_ORR: op_val = x | y;
            default:  op_val = diff;
        endcase
    end

    always_comb
    begin
        res           = '0;
        res.flags_now = flags;
        res.pc_now    = pc;
        if (pass)
        begin
            if (req.kind > KIND_SUB)
            begin
                res.fault = FAULT_KIND;
            end
            else if (!ok)
            begin
                res.fault = FAULT_COUNT;
            end
            else
            begin
                res.executed = 1'b1;
                case (req.kind)
                    KIND_B:
                    begin
                        res.pc_now       = req.jump_target;
                        res.branch_taken = 1'b1;
                    end
                    KIND_CMP:
                    begin
                        res.result_value = diff;
                        res.flags_now    = sub_f;
                    end
                    KIND_SUB:
                    begin
                        res.result_value  = diff;
                        res.reg_written   = 1'b1;
                        res.written_index = wr_index;
                        if (req.set_flags)
                        begin
                            res.flags_now = sub_f;
                        end
                    end
                    default:
                    begin
                        res.result_value  = op_val;
                        res.reg_written   = 1'b1;
                        res.written_index = wr_index;
                        if (req.set_flags)
                        begin
                            res.flags_now[FLAG_N] = op_val[WORD_W-1];
                            res.flags_now[FLAG_Z] = (op_val == '0);
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/conditional_alu_with_flags_unit.sv =====
// ----------------------------------------------------------------------------
// conditional_alu_with_flags_unit
// Conditional ALU with NZCV flags, register file, program counter.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready/req_data, one decoded instruction
//   each; results leave on res_valid/res_ready/res_data, one per request,
//   in order.
//   An accepted request is held in the execute stage, then its result in
//   the result register. Throughput: one request per cycle while the result
//   channel is not stalled. The register file is read at accept time through
//   two registered ports; a write in the same cycle is forwarded, so
//   back-to-back dependent requests need no wait. Flags and the program
//   counter are registers read in the execute stage.
//   Reset: register file reads as zero (per-entry valid bits), flags and
//   program counter clear, both pipeline stages empty. No clearing pass.
//   Stall: while res_valid is high and res_ready low, the result register
//   holds; the execute stage still takes one more request, then holds it
//   and drops req_ready until the result is taken.
// ----------------------------------------------------------------------------
module conditional_alu_with_flags_unit
    import caf_pkg::*;
#(
    parameter int REG_COUNT = CAF_REG_COUNT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_ready,
    output res_t res_data
);

    `include "assert_macros.svh"

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int IW = (REG_COUNT > 16) ? $clog2(REG_COUNT) + 1 : 5;

    function automatic logic [AW-1:0] wrap_idx(input logic [3:0] idx);
        logic [IW-1:0] val;
        val = IW'(idx);
        for (int i = 0; i < 8; i++)
        begin
            if (val >= IW'(REG_COUNT))
            begin
                val = val - IW'(REG_COUNT);
            end
        end
        return AW'(val);
    endfunction

    logic              req_acc;
    logic              s1_adv;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    req_t              s1_req_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    res_t              out_data_reg;
    logic [3:0]        flags_reg;
    logic [WORD_W-1:0] pc_reg;
    logic [AW-1:0]     raddr0;
    logic [AW-1:0]     raddr1;
    logic [WORD_W-1:0] rdata0;
    logic [WORD_W-1:0] rdata1;
    logic [AW-1:0]     s1_dest;
    logic [WORD_W-1:0] av;
    logic [WORD_W-1:0] bv;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic              s1_two;
    res_t              exec_res;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign req_acc   = req_valid && req_ready;

    // two-operand forms read dest and a; all other forms read a and b
    always_comb
    begin
        if (req_data.operand_count == CNT_TWO)
        begin
            raddr0 = wrap_idx(req_data.dest_reg);
            raddr1 = wrap_idx(req_data.a_reg);
        end
        else
        begin
            raddr0 = wrap_idx(req_data.a_reg);
            raddr1 = wrap_idx(req_data.b_reg);
        end
    end

    assign s1_dest = wrap_idx(s1_req_reg.dest_reg);

    caf_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (req_acc),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1),
        .we     (s1_adv && exec_res.reg_written),
        .waddr  (s1_dest),
        .wdata  (exec_res.result_value)
    );

    assign s1_two = (s1_req_reg.operand_count == CNT_TWO);
    assign av = s1_req_reg.a_is_reg ? (s1_two ? rdata1 : rdata0) : s1_req_reg.a_imm;
    assign bv = s1_req_reg.b_is_reg ? rdata1 : s1_req_reg.b_imm;
    assign x  = s1_two ? rdata0 : av;
    assign y  = s1_two ? av : bv;

    caf_exec u_exec (
        .req      (s1_req_reg),
        .x        (x),
        .y        (y),
        .flags    (flags_reg),
        .pc       (pc_reg),
        .wr_index (4'(s1_dest)),
        .res      (exec_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            pc_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                flags_reg <= exec_res.flags_now;
                pc_reg    <= exec_res.pc_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_req_reg <= req_data;
        end
        if (s1_adv)
        begin
            out_data_reg <= exec_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    `CAF_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_req_reg), "execute stage dropped a stalled request")
    `CAF_ASSERT_NOW(a_fault_no_effect, res_valid && (res_data.fault != FAULT_OK),
        !res_data.reg_written && !res_data.executed && !res_data.branch_taken,
        "faulted result has side effects")
    `CAF_ASSERT_NEXT(a_pc_branch_only, s1_adv && !exec_res.branch_taken,
        pc_reg == $past(pc_reg), "program counter moved without a branch")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Conditional ALU with flags: self-checking bench
// Drives decoded instructions through the request channel with random gaps,
// stalls the result channel at random, checks every result field against a
// directed row's given result or an in-bench model of registers, NZCV and pc.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import caf_pkg::*;

    localparam logic [4:0] COND_NONE  = 5'd0;
    localparam logic [4:0] COND_AL    = 5'd15;
    localparam logic [4:0] COND_UNDEF = 5'd31;
    localparam logic [3:0] KIND_UNSUP = 4'd10;
    localparam logic [3:0] KIND_TOP   = 4'd15;
    localparam logic [1:0] CNT_ZERO   = 2'd0;
    localparam int RANDOM_ITEMS       = 2000;
    localparam int LONG_HOLD          = 300;

    typedef struct {
        req_t req;
        bit   typed;
        res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res_data;

    logic [31:0] arch_regs [CAF_REG_COUNT];
    logic [3:0]  arch_flags = '0;
    logic [31:0] arch_pc = '0;

    res_t      pending_results [$];
    stim_row_t stim_rows [$];

    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int n_exec = 0;
    int n_skip = 0;
    int n_fault = 0;
    int n_branch = 0;

    conditional_alu_with_flags_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (arch_regs[i])
            arch_regs[i] = '0;
    end

    function automatic logic [3:0] sub_nzcv(logic [31:0] x, logic [31:0] y, logic [31:0] r);
        logic [3:0] f;
        f = '0;
        f[FLAG_N] = r[31];
        f[FLAG_Z] = (r == '0);
        f[FLAG_C] = (x >= y);
        f[FLAG_V] = (x[31] ^ y[31]) & (x[31] ^ r[31]);
        return f;
    endfunction

    function automatic res_t execute_instr(req_t r);
        res_t        o;
        logic [31:0] av;
        logic [31:0] bv;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] res;
        logic        n;
        logic        z;
        logic        c;
        logic        v;
        logic        cond_ok;
        logic        count_ok;
        o = '0;
        res = '0;
        n = arch_flags[FLAG_N];
        z = arch_flags[FLAG_Z];
        c = arch_flags[FLAG_C];
        v = arch_flags[FLAG_V];
        av = r.a_is_reg ? arch_regs[r.a_reg] : r.a_imm;
        bv = r.b_is_reg ? arch_regs[r.b_reg] : r.b_imm;
        x = (r.operand_count == CNT_TWO) ? arch_regs[r.dest_reg] : av;
        y = (r.operand_count == CNT_TWO) ? av : bv;
        case (r.cond)
            COND_EQ: cond_ok = z;
            COND_NE: cond_ok = !z;
            COND_CS: cond_ok = c;
            COND_CC: cond_ok = !c;
            COND_MI: cond_ok = n;
            COND_PL: cond_ok = !n;
            COND_VS: cond_ok = v;
            COND_VC: cond_ok = !v;
            COND_HI: cond_ok = c && !z;
            COND_LS: cond_ok = !c || z;
            COND_GE: cond_ok = (n == v);
            COND_LT: cond_ok = (n != v);
            COND_GT: cond_ok = !z && (n == v);
            COND_LE: cond_ok = z || (n != v);
            default: cond_ok = 1'b1;
        endcase
        case (r.kind)
            KIND_ADD, KIND_BIC, KIND_SUB:
                count_ok = (r.operand_count == CNT_TWO) || (r.operand_count == CNT_THREE);
            KIND_AND, KIND_EOR, KIND_MUL, KIND_ORR:
                count_ok = (r.operand_count == CNT_THREE);
            KIND_CMP, KIND_MOV:
                count_ok = (r.operand_count == CNT_TWO);
            KIND_B:
                count_ok = (r.operand_count == CNT_ONE);
            default:
                count_ok = 1'b0;
        endcase
        if (cond_ok)
        begin
            if (r.kind > KIND_SUB)
                o.fault = FAULT_KIND;
            else if (!count_ok)
                o.fault = FAULT_COUNT;
            else
            begin
                o.executed = 1'b1;
                o.reg_written = (r.kind != KIND_B) && (r.kind != KIND_CMP);
                case (r.kind)
                    KIND_ADD: res = x + y;
                    KIND_AND: res = x & y;
                    KIND_BIC: res = x & ~y;
                    KIND_EOR: res = x ^ y;
                    KIND_MOV: res = y;
                    KIND_MUL: res = x * y;
                    KIND_ORR: res = x | y;
                    KIND_B:
                    begin
                        arch_pc = r.jump_target;
                        o.branch_taken = 1'b1;
                    end
                    KIND_CMP:
                    begin
                        res = x - y;
                        arch_flags = sub_nzcv(x, y, res);
                    end
                    default:
                    begin
                        res = x - y;
                        if (r.set_flags)
                            arch_flags = sub_nzcv(x, y, res);
                    end
                endcase
                if (o.reg_written)
                begin
                    arch_regs[r.dest_reg] = res;
                    o.written_index = r.dest_reg;
                    if (r.set_flags && r.kind != KIND_SUB)
                    begin
                        arch_flags[FLAG_N] = res[31];
                        arch_flags[FLAG_Z] = (res == '0);
                    end
                end
                o.result_value = res;
            end
        end
        o.flags_now = arch_flags;
        o.pc_now = arch_pc;
        return o;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void compare_result(res_t got);
        res_t want;
        if (pending_results.size() == 0)
        begin
            $error("result arrived with no request outstanding");
            errors++;
            return;
        end
        want = pending_results.pop_front();
        check_field("executed", 32'(want.executed), 32'(got.executed));
        check_field("reg_written", 32'(want.reg_written), 32'(got.reg_written));
        check_field("written_index", 32'(want.written_index), 32'(got.written_index));
        check_field("result_value", want.result_value, got.result_value);
        check_field("flags_now", 32'(want.flags_now), 32'(got.flags_now));
        check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
        check_field("pc_now", want.pc_now, got.pc_now);
        check_field("fault", 32'(want.fault), 32'(got.fault));
    endfunction

    function automatic void add_row(req_t r, bit typed, res_t want);
        stim_row_t e;
        e.req = r;
        e.typed = typed;
        e.want = want;
        stim_rows.push_back(e);
    endfunction

    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'hFFFF_FFFF;
            5: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   p;
        r.set_flags = 1'($urandom_range(0, 1));
        r.dest_reg = 4'($urandom_range(0, 15));
        r.a_is_reg = 1'($urandom_range(0, 1));
        r.a_reg = 4'($urandom_range(0, 15));
        r.a_imm = pick_word();
        r.b_is_reg = 1'($urandom_range(0, 1));
        r.b_reg = 4'($urandom_range(0, 15));
        r.b_imm = pick_word();
        r.jump_target = $urandom;
        p = $urandom_range(0, 99);
        if (p < 30)
            r.cond = COND_AL;
        else if (p < 45)
            r.cond = COND_NONE;
        else if (p < 90)
            r.cond = 5'($urandom_range(COND_EQ, COND_LE));
        else
            r.cond = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 85)
        begin
            r.kind = 4'($urandom_range(KIND_ADD, KIND_SUB));
            case (r.kind)
                KIND_ADD, KIND_BIC, KIND_SUB:
                    r.operand_count = 2'($urandom_range(CNT_TWO, CNT_THREE));
                KIND_CMP, KIND_MOV:           r.operand_count = CNT_TWO;
                KIND_B:                       r.operand_count = CNT_ONE;
                default:                      r.operand_count = CNT_THREE;
            endcase
        end
        else
        begin
            r.kind = 4'($urandom_range(0, 15));
            r.operand_count = 2'($urandom_range(0, 3));
        end
        return r;
    endfunction

    task automatic push_request(req_t r, bit typed, res_t want, int gap);
        res_t pred;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (!req_ready);
        pred = execute_instr(r);
        pending_results.push_back(typed ? want : pred);
        requests_sent++;
        if (pred.executed)
            n_exec++;
        else if (pred.fault != FAULT_OK)
            n_fault++;
        else
            n_skip++;
        if (pred.branch_taken)
            n_branch++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // faults first, while flags and pc are still at their reset values
        add_row(req_t'{KIND_TOP, COND_NONE, 1'b0, CNT_THREE, 4'd0, 1'b0, 4'd0, 32'd0,
                       1'b0, 4'd0, 32'd0, 32'd0},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_KIND});
        add_row(req_t'{KIND_UNSUP, COND_AL, 1'b1, CNT_TWO, 4'd3, 1'b1, 4'd3, 32'hFFFF_FFFF,
                       1'b1, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_KIND});
        add_row(req_t'{KIND_ADD, COND_AL, 1'b1, CNT_ONE, 4'd1, 1'b0, 4'd0, 32'd5,
                       1'b0, 4'd0, 32'd6, 32'd0},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_COUNT});
        add_row(req_t'{KIND_B, COND_NONE, 1'b0, CNT_TWO, 4'd0, 1'b0, 4'd0, 32'd0,
                       1'b0, 4'd0, 32'd0, 32'h1234_5678},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_COUNT});
        add_row(req_t'{KIND_MOV, COND_AL, 1'b1, CNT_THREE, 4'd2, 1'b0, 4'd0, 32'd7,
                       1'b0, 4'd0, 32'd8, 32'd0},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_COUNT});
        add_row(req_t'{KIND_AND, COND_AL, 1'b0, CNT_ZERO, 4'd2, 1'b0, 4'd0, 32'd7,
                       1'b0, 4'd0, 32'd8, 32'd0},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_COUNT});
        add_row(req_t'{KIND_CMP, COND_AL, 1'b0, CNT_THREE, 4'd2, 1'b0, 4'd0, 32'd7,
                       1'b0, 4'd0, 32'd8, 32'd0},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_COUNT});
        // condition fails, so even a bad kind reports no fault
        add_row(req_t'{KIND_TOP, COND_EQ, 1'b1, CNT_ZERO, 4'd0, 1'b0, 4'd0, 32'd0,
                       1'b0, 4'd0, 32'd0, 32'd0},
                1'b1, res_t'{1'b0, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b0, 32'd0, FAULT_OK});
        add_row(req_t'{KIND_B, COND_AL, 1'b1, CNT_ONE, 4'd0, 1'b0, 4'd0, 32'd0,
                       1'b0, 4'd0, 32'd0, 32'hFFFF_FFFF},
                1'b1, res_t'{1'b1, 1'b0, 4'd0, 32'd0, 4'b0000, 1'b1, 32'hFFFF_FFFF, FAULT_OK});
        add_row(req_t'{KIND_MOV, COND_UNDEF, 1'b1, CNT_TWO, 4'd1, 1'b0, 4'd0, 32'hFFFF_FFFF,
                       1'b0, 4'd0, 32'd0, 32'd0},
                1'b1, res_t'{1'b1, 1'b1, 4'd1, 32'hFFFF_FFFF, 4'b1000, 1'b0, 32'hFFFF_FFFF,
                             FAULT_OK});
        add_row(req_t'{KIND_ADD, COND_AL, 1'b1, CNT_THREE, 4'd2, 1'b1, 4'd1, 32'd0,
                       1'b0, 4'd0, 32'd1, 32'd0},
                1'b1, res_t'{1'b1, 1'b1, 4'd2, 32'd0, 4'b0100, 1'b0, 32'hFFFF_FFFF, FAULT_OK});
        add_row(req_t'{KIND_B, COND_EQ, 1'b0, CNT_ONE, 4'd0, 1'b0, 4'd0, 32'd0,
                       1'b0, 4'd0, 32'd0, 32'd0},
                1'b1, res_t'{1'b1, 1'b0, 4'd0, 32'd0, 4'b0100, 1'b1, 32'd0, FAULT_OK});
        add_row(req_t'{KIND_CMP, COND_AL, 1'b0, CNT_TWO, 4'd1, 1'b0, 4'd0, 32'd1,
                       1'b0, 4'd0, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_SUB, COND_NONE, 1'b1, CNT_THREE, 4'd3, 1'b0, 4'd0, 32'd0,
                       1'b0, 4'd0, 32'd1, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_SUB, COND_AL, 1'b1, CNT_THREE, 4'd4, 1'b0, 4'd0, 32'h8000_0000,
                       1'b0, 4'd0, 32'd1, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_ADD, COND_AL, 1'b0, CNT_TWO, 4'd15, 1'b1, 4'd1, 32'd0,
                       1'b0, 4'd0, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_MUL, COND_AL, 1'b1, CNT_THREE, 4'd5, 1'b0, 4'd0, 32'hFFFF_FFFF,
                       1'b0, 4'd0, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_BIC, COND_AL, 1'b1, CNT_THREE, 4'd6, 1'b1, 4'd1, 32'd0,
                       1'b0, 4'd0, 32'h0F0F_0F0F, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_EOR, COND_AL, 1'b1, CNT_THREE, 4'd7, 1'b1, 4'd1, 32'd0,
                       1'b1, 4'd1, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_ORR, COND_AL, 1'b1, CNT_THREE, 4'd0, 1'b0, 4'd0, 32'h8000_0000,
                       1'b1, 4'd14, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_BIC, COND_AL, 1'b0, CNT_TWO, 4'd1, 1'b0, 4'd0, 32'h0000_00FF,
                       1'b0, 4'd0, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_SUB, COND_AL, 1'b0, CNT_TWO, 4'd1, 1'b0, 4'd0, 32'd1,
                       1'b0, 4'd0, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_CMP, COND_AL, 1'b0, CNT_TWO, 4'd2, 1'b0, 4'd0, 32'd0,
                       1'b0, 4'd0, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_MOV, COND_HI, 1'b1, CNT_TWO, 4'd8, 1'b0, 4'd0, 32'd5,
                       1'b0, 4'd0, 32'd0, 32'd0}, 1'b0, '0);
        add_row(req_t'{KIND_MOV, COND_LS, 1'b1, CNT_TWO, 4'd8, 1'b0, 4'd0, 32'd5,
                       1'b0, 4'd0, 32'd0, 32'd0}, 1'b0, '0);
    end

    initial
    begin
        int  gap;
        bit  quiet;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_rows[i])
            push_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want, draw_gap());
        req_valid <= 1'b0;
        wait_drained();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
            begin
                // hold until every outstanding result is back
                req_valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
            quiet = ((i / 150) % 4 == 1);
            gap = quiet ? 0 : draw_gap();
            push_request(random_req(), 1'b0, '0, gap);
        end
        req_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        $display("%0d requests, %0d results checked: %0d executed, %0d skipped, %0d faults,",
                 requests_sent, results_seen, n_exec, n_skip, n_fault);
        $display("%0d branches taken, long result stall of %0d cycles applied once.",
                 n_branch, LONG_HOLD);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                compare_result(res_data);
                results_seen++;
            end
            if (!long_done && results_seen >= 600)
            begin
                long_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                res_ready <= 1'b0;
            end
            else if ((results_seen / 170) % 3 == 2)
                res_ready <= 1'b1;
            else
            begin
                hold = draw_gap();
                if (hold == 0)
                    res_ready <= 1'b1;
                else
                begin
                    hold--;
                    res_ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $error("run did not complete in time, %0d results still outstanding",
               pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
